/* hw/rtl/pet_pkg.sv */
`default_nettype none
package pet_pkg;

   localparam int CMD_W    = 3;
   localparam int CH_W     = 3;
   localparam int PERIOD_W = 16;
   localparam int TIME_W   = 29;
   localparam int TICK_W   = 32;

   localparam int DEF_NUM_CHANNELS = 8;

   localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd1024;

   // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
   localparam logic [TICK_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int                DIV10_SHIFT = 35;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_SET_PERIOD = 3'd1,
      CMD_READ_FLAG  = 3'd2,
      CMD_CLEAR_FLAG = 3'd3,
      CMD_READ_TIME  = 3'd4,
      CMD_TAKE_FLAG  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_TIME
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/pet_ram.sv */
`default_nettype none
module pet_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/pet_div10.sv */
`default_nettype none
module pet_div10 (
   input  logic                        clock,
   input  logic [pet_pkg::TICK_W-1:0]  ticks,
   output logic [pet_pkg::TIME_W-1:0]  ms
);
   import pet_pkg::*;

   logic [2*TICK_W-1:0] prod_ff;
   logic [2*TICK_W-1:0] prod_in;

   // reciprocal multiply, quotient taken from the top bits
   assign prod_in = {{TICK_W{1'b0}}, ticks} * {{TICK_W{1'b0}}, DIV10_RECIP};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign ms = prod_ff[DIV10_SHIFT +: TIME_W];

endmodule
`default_nettype wire

/* hw/rtl/periodic_event_timer_bank.sv */
`default_nettype none
// periodic_event_timer_bank
//
// Commands enter on start / req_* and are taken at a clock edge where start
// is high and busy is low. Every command returns exactly one item on the
// rsp_* ports, marked by a one-cycle rsp_strobe; the receiver cannot stall.
// From acceptance to rsp_strobe:
//   set period, read / clear / take flag, unused codes: rsp_strobe is
//   registered directly, busy stays low, so these can be issued every cycle
//   read time: product register, then response register (registered
//   multiply by the reciprocal of 10)
//   tick: busy high while the counter/period memory is read, updated and
//   written back one channel per cycle through its single read port
// Counters and periods live in one memory; per-channel valid bits make an
// unwritten entry read as the reset period of 1024, so no clearing pass is
// needed. Reset is synchronous and active high; the block takes a command
// in the cycle after reset is released. Flags and the tick count reset to 0.
module periodic_event_timer_bank #(
   parameter int NUM_CHANNELS = pet_pkg::DEF_NUM_CHANNELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pet_pkg::CMD_W-1:0]     req_command,
   input  logic [pet_pkg::CH_W-1:0]      req_channel,
   input  logic [pet_pkg::PERIOD_W-1:0]  req_period_value,
   output logic                          rsp_strobe,
   output logic                          rsp_flag_out,
   output logic [pet_pkg::TIME_W-1:0]    rsp_time_ms
);
   import pet_pkg::*;

   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ENTRY_W = 2 * PERIOD_W;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_CHANNELS - 1);

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [TICK_W-1:0]        tick_count_ff, tick_count_in;
   logic [NUM_CHANNELS-1:0]  flags_ff, flags_in;
   logic [NUM_CHANNELS-1:0]  valid_ff, valid_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic                     rsp_flag_ff, rsp_flag_in;
   logic [TIME_W-1:0]        rsp_time_ff, rsp_time_in;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]       rd_data;
   logic [TIME_W-1:0]        ms_value;

   cmd_type                  req_cmd;
   logic                     ch_ok;
   logic [ADDR_W-1:0]        ch_addr;

   logic [ENTRY_W-1:0]       cur_entry;
   logic [PERIOD_W-1:0]      cur_cnt;
   logic [PERIOD_W-1:0]      cur_per;
   logic                     fire;
   logic [ENTRY_W-1:0]       walk_data;
   logic                     tick_last;

   pet_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CHANNELS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pet_div10 u_div10 (
      .clock (clock),
      .ticks (tick_count_ff),
      .ms    (ms_value)
   );

   assign req_cmd = cmd_type'(req_command);
   assign ch_ok   = (32'(req_channel) < NUM_CHANNELS);
   assign ch_addr = ADDR_W'(req_channel);

   // entry layout: period in the upper half, down counter in the lower
   always_comb begin
      cur_entry = valid_ff[idx_ff] ? rd_data : {RESET_PERIOD, RESET_PERIOD};
      cur_per   = cur_entry[ENTRY_W-1:PERIOD_W];
      cur_cnt   = cur_entry[PERIOD_W-1:0];
      fire      = (cur_cnt == '0);
      walk_data = fire ? {cur_per, cur_per} : {cur_per, cur_cnt - PERIOD_W'(1)};
   end

   assign tick_last = (idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         tick_count_ff <= '0;
         flags_ff      <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_flag_ff   <= 1'b0;
         rsp_time_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         tick_count_ff <= tick_count_in;
         flags_ff      <= flags_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_flag_ff   <= rsp_flag_in;
         rsp_time_ff   <= rsp_time_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      tick_count_in = tick_count_ff;
      flags_in      = flags_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_flag_in   = 1'b0;
      rsp_time_in   = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = walk_data;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_TICK: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = ST_TICK;
                  end
                  CMD_SET_PERIOD: begin
                     rsp_strobe_in = 1'b1;
                     if (ch_ok) begin
                        wr_en             = 1'b1;
                        wr_addr           = ch_addr;
                        wr_data           = {req_period_value, req_period_value};
                        valid_in[ch_addr] = 1'b1;
                        flags_in[ch_addr] = 1'b0;
                     end
                  end
                  CMD_READ_FLAG: begin
                     rsp_strobe_in = 1'b1;
                     if (ch_ok) begin
                        rsp_flag_in = flags_ff[ch_addr];
                     end
                  end
                  CMD_CLEAR_FLAG: begin
                     rsp_strobe_in = 1'b1;
                     if (ch_ok) begin
                        flags_in[ch_addr] = 1'b0;
                     end
                  end
                  CMD_READ_TIME: begin
                     // product is captured at this edge, quotient ready next cycle
                     state_in = ST_TIME;
                  end
                  CMD_TAKE_FLAG: begin
                     rsp_strobe_in = 1'b1;
                     if (ch_ok) begin
                        rsp_flag_in       = flags_ff[ch_addr];
                        flags_in[ch_addr] = 1'b0;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_TICK: begin
            // write back this channel while the next one is read
            wr_en            = 1'b1;
            wr_addr          = idx_ff;
            wr_data          = walk_data;
            valid_in[idx_ff] = 1'b1;
            if (fire) begin
               flags_in[idx_ff] = 1'b1;
            end
            if (tick_last) begin
               tick_count_in = tick_count_ff + TICK_W'(1);
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(idx_ff + ADDR_W'(1));
               idx_in  = ADDR_W'(idx_ff + ADDR_W'(1));
            end
         end
         ST_TIME: begin
            rsp_strobe_in = 1'b1;
            rsp_time_in   = ms_value;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_flag_out = rsp_flag_ff;
   assign rsp_time_ms  = rsp_time_ff;

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK |-> idx_ff <= LAST_IDX)
      else $error("channel walk index past last channel");

   a_tick_ends_with_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK && tick_last) |=>
         rsp_strobe_ff && state_ff == ST_IDLE
         && tick_count_ff == $past(tick_count_ff) + TICK_W'(1))
      else $error("tick did not complete with one item and a count step");

   a_tick_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_TICK) |=> busy && !rsp_strobe_ff)
      else $error("accepted tick did not start the channel walk");

   a_time_only_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_time_ff != '0 |-> $past(state_ff) == ST_TIME)
      else $error("time reported outside a read time command");

   a_no_write_when_idle_walk: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_IDLE) |-> (start && req_command == CMD_SET_PERIOD))
      else $error("memory write outside set period or tick walk");

endmodule
`default_nettype wire

/* tb/sv/periodic_event_timer_bank_tb.sv */
module periodic_event_timer_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pet_pkg::*;

   localparam int NUM_CH        = DEF_NUM_CHANNELS;
   localparam int NUM_DIRECTED  = 22;
   localparam int NUM_RANDOM    = 730;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = NUM_CH + 4;
   localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic              flag;
      logic [TIME_W-1:0] ms;
   } timer_reply_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [CH_W-1:0]     ch;
      logic [PERIOD_W-1:0] per;
      logic                typed;
      timer_reply_type     reply;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_command;
   logic [CH_W-1:0]     req_channel;
   logic [PERIOD_W-1:0] req_period_value;
   logic                rsp_strobe;
   logic                rsp_flag_out;
   logic [TIME_W-1:0]   rsp_time_ms;

   // mirror of the timer bank state
   logic [PERIOD_W-1:0] counter_mirror [NUM_CH];
   logic [PERIOD_W-1:0] period_mirror [NUM_CH];
   logic                flag_mirror [NUM_CH];
   logic [TICK_W-1:0]   tick_mirror;

   timer_reply_type pending_replies [$];
   stim_row_type    stim_rows [NUM_DIRECTED];

   int error_count;
   int stall_cycles;
   int replies_checked;
   int flags_seen_set;
   int ticks_issued;

   periodic_event_timer_bank #(
      .NUM_CHANNELS(NUM_CH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_channel     (req_channel),
      .req_period_value(req_period_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_flag_out    (rsp_flag_out),
      .rsp_time_ms     (rsp_time_ms)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic timer_reply_type apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [CH_W-1:0] ch,
                                                     input logic [PERIOD_W-1:0] per);
      timer_reply_type reply;
      reply = '0;
      case (cmd)
         CMD_TICK: begin
            for (int k = 0; k < NUM_CH; k++) begin
               if (counter_mirror[k] != '0) begin
                  counter_mirror[k] = counter_mirror[k] - 1'b1;
               end else begin
                  counter_mirror[k] = period_mirror[k];
                  flag_mirror[k] = 1'b1;
               end
            end
            tick_mirror = tick_mirror + 1'b1;
         end
         CMD_SET_PERIOD: begin
            counter_mirror[ch] = per;
            period_mirror[ch] = per;
            flag_mirror[ch] = 1'b0;
         end
         CMD_READ_FLAG: reply.flag = flag_mirror[ch];
         CMD_CLEAR_FLAG: flag_mirror[ch] = 1'b0;
         CMD_READ_TIME: reply.ms = TIME_W'(tick_mirror / 32'd10);
         CMD_TAKE_FLAG: begin
            reply.flag = flag_mirror[ch];
            flag_mirror[ch] = 1'b0;
         end
         default: ;
      endcase
      return reply;
   endfunction

   function automatic int pick_gap(input int idx);
      int r;
      r = $urandom_range(0, 99);
      // every fourth stretch of 60 items runs back to back
      if ((idx / 60) % 4 == 1) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                                input logic [PERIOD_W-1:0] per, input logic typed,
                                input timer_reply_type typed_reply, input int gap);
      timer_reply_type predicted;
      req_command <= cmd;
      req_channel <= ch;
      req_period_value <= per;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_command(cmd, ch, per);
      pending_replies.push_back(typed ? typed_reply : predicted);
      if (cmd == CMD_TICK) ticks_issued++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_replies();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // result checking and watchdog
   always @(posedge clock) begin
      timer_reply_type want;
      if (!reset) begin
         if (rsp_strobe || (start && !busy)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (rsp_strobe) begin
            if (pending_replies.size() == 0) begin
               $error("unexpected result: flag_out=%0d time_ms=%0d", rsp_flag_out, rsp_time_ms);
               error_count++;
            end else begin
               want = pending_replies.pop_front();
               replies_checked++;
               if (rsp_flag_out) flags_seen_set++;
               if (rsp_flag_out !== want.flag) begin
                  $error("flag_out mismatch: expected %0d, got %0d", want.flag, rsp_flag_out);
                  error_count++;
               end
               if (rsp_time_ms !== want.ms) begin
                  $error("time_ms mismatch: expected %0d, got %0d", want.ms, rsp_time_ms);
                  error_count++;
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("periodic_event_timer_bank_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      logic [CMD_W-1:0]    cmd;
      logic [CH_W-1:0]     ch;
      logic [PERIOD_W-1:0] per;
      int                  r;
      int                  gap;

      reset = 1'b1;
      start = 1'b0;
      req_command = '0;
      req_channel = '0;
      req_period_value = '0;
      error_count = 0;
      stall_cycles = 0;
      replies_checked = 0;
      flags_seen_set = 0;
      ticks_issued = 0;
      for (int k = 0; k < NUM_CH; k++) begin
         counter_mirror[k] = RESET_PERIOD;
         period_mirror[k] = RESET_PERIOD;
         flag_mirror[k] = 1'b0;
      end
      tick_mirror = '0;

      stim_rows = '{
         '{CMD_READ_TIME,  3'd0, 16'h0000, 1'b1, '{1'b0, 29'd0}},
         '{CMD_READ_FLAG,  3'd0, 16'h0000, 1'b1, '{1'b0, 29'd0}},
         '{CMD_TAKE_FLAG,  3'd7, 16'hFFFF, 1'b1, '{1'b0, 29'd0}},
         '{CMD_UNUSED_6,   3'd7, 16'hFFFF, 1'b1, '{1'b0, 29'd0}},
         '{CMD_UNUSED_7,   3'd5, 16'h5555, 1'b1, '{1'b0, 29'd0}},
         '{CMD_CLEAR_FLAG, 3'd2, 16'h0000, 1'b1, '{1'b0, 29'd0}},
         '{CMD_SET_PERIOD, 3'd0, 16'h0000, 1'b1, '{1'b0, 29'd0}},
         '{CMD_SET_PERIOD, 3'd7, 16'hFFFF, 1'b1, '{1'b0, 29'd0}},
         '{CMD_SET_PERIOD, 3'd3, 16'h0001, 1'b1, '{1'b0, 29'd0}},
         '{CMD_SET_PERIOD, 3'd5, 16'hAAAA, 1'b1, '{1'b0, 29'd0}},
         '{CMD_TICK,       3'd0, 16'h0000, 1'b1, '{1'b0, 29'd0}},
         '{CMD_READ_FLAG,  3'd0, 16'h0000, 1'b0, '0},
         '{CMD_TAKE_FLAG,  3'd0, 16'h0000, 1'b0, '0},
         '{CMD_READ_FLAG,  3'd0, 16'h0000, 1'b0, '0},
         '{CMD_TICK,       3'd6, 16'hFFFF, 1'b1, '{1'b0, 29'd0}},
         '{CMD_TICK,       3'd1, 16'h0000, 1'b1, '{1'b0, 29'd0}},
         '{CMD_READ_FLAG,  3'd3, 16'h0000, 1'b0, '0},
         '{CMD_CLEAR_FLAG, 3'd3, 16'h0000, 1'b1, '{1'b0, 29'd0}},
         '{CMD_READ_FLAG,  3'd3, 16'h0000, 1'b0, '0},
         '{CMD_TAKE_FLAG,  3'd7, 16'h0000, 1'b0, '0},
         '{CMD_READ_TIME,  3'd0, 16'h0000, 1'b0, '0},
         '{CMD_SET_PERIOD, 3'd2, 16'h5555, 1'b1, '{1'b0, 29'd0}}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         gap = (i == NUM_DIRECTED - 1) ? 1 : pick_gap(i + 60);
         issue_command(stim_rows[i].cmd, stim_rows[i].ch, stim_rows[i].per,
                       stim_rows[i].typed, stim_rows[i].reply, gap);
      end
      // hold off until the directed results have drained
      wait_all_replies();

      for (int i = 0; i < NUM_RANDOM; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) cmd = CMD_TICK;
         else if (r < 50) cmd = CMD_SET_PERIOD;
         else if (r < 62) cmd = CMD_READ_FLAG;
         else if (r < 70) cmd = CMD_CLEAR_FLAG;
         else if (r < 78) cmd = CMD_READ_TIME;
         else if (r < 93) cmd = CMD_TAKE_FLAG;
         else cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_7 : CMD_UNUSED_6;
         ch = CH_W'($urandom_range(0, NUM_CH - 1));
         // short periods keep the flags firing; a few span the full range
         r = $urandom_range(0, 99);
         if (r < 70) per = PERIOD_W'($urandom_range(0, 12));
         else if (r < 88) per = PERIOD_W'($urandom_range(0, 60));
         else per = PERIOD_W'($urandom_range(0, 65535));
         gap = pick_gap(i);
         if (i == NUM_RANDOM / 2 || i == NUM_RANDOM - 1) gap = (gap == 0) ? 1 : gap;
         issue_command(cmd, ch, per, 1'b0, '0, gap);
         if (i == NUM_RANDOM / 2) wait_all_replies();
      end

      wait_all_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random items, %0d ticks, %0d results checked",
               NUM_DIRECTED, NUM_RANDOM, ticks_issued, replies_checked);
      $display("flag reads that returned a set flag: %0d", flags_seen_set);
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("periodic_event_timer_bank_tb: clean");
      end else begin
         $display("periodic_event_timer_bank_tb: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/pet_pkg.sv
hw/rtl/pet_ram.sv
hw/rtl/pet_div10.sv
hw/rtl/periodic_event_timer_bank.sv
tb/sv/periodic_event_timer_bank_tb.sv
